// ===== hw/rtl/tkhm_pkg.sv =====
package tkhm_pkg;

    localparam int KEY_W       = 16;
    localparam int VAL_W       = 32;
    localparam int BUCKETS_DEF = 64;
    localparam int POOL_DEF    = 256;
    localparam int HASH_MUL    = 31;

    // |key_a*31 + key_b| never exceeds 2**20, so a bias of at least that much
    // makes the hash non-negative and the biased value fits in 22 bits
    localparam int HASH_BIAS_EXP = 20;
    localparam int HASH_W        = 22;

    localparam int QUEUE_DEPTH = 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic signed [VAL_W-1:0] VALUE_NONE = '1;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key_a;
        logic signed [KEY_W-1:0] key_b;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PROD,
        F_MOD
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_HEAD,
        B_WALK,
        B_LINK
    } back_state_t;

endpackage

// ===== hw/rtl/tkhm_front.sv =====
module tkhm_front #(
    parameter int BUCKETS = tkhm_pkg::BUCKETS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  tkhm_pkg::req_t               req,
    output logic                         busy,
    output logic                         push_valid,
    input  logic                         push_ready,
    output tkhm_pkg::req_t               item,
    output logic [$clog2(BUCKETS)-1:0]   bucket
);
    import tkhm_pkg::*;

    localparam int BW    = $clog2(BUCKETS);
    localparam int HW    = HASH_W + 2;
    localparam int BIAS  = BUCKETS * ((2**HASH_BIAS_EXP + BUCKETS - 1) / BUCKETS);
    localparam int SHIFT = HASH_W + BW;
    localparam int RW    = HASH_W + 2;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << SHIFT) / 64'(BUCKETS));

    front_state_t state_reg, state_next;

    req_t              req_reg;
    logic [HASH_W-1:0] u_reg;
    logic [HASH_W-1:0] q_reg;
    logic [HASH_W-1:0] qb_reg;

    logic signed [HW-1:0]     ka_x, kb_x, h_sum;
    logic [HASH_W+RW-1:0]     prod_full;
    logic [HASH_W-1:0]        q_next;
    logic [HASH_W-1:0]        qb_next;
    logic [HASH_W-1:0]        rem_raw, rem_fix;

    // biased hash, always non-negative
    assign ka_x  = HW'(req.key_a);
    assign kb_x  = HW'(req.key_b);
    assign h_sum = ka_x * HW'(HASH_MUL) + kb_x + HW'(BIAS);

    // quotient estimate by reciprocal, low by at most one
    assign prod_full = u_reg * RECIP;
    assign q_next    = HASH_W'(prod_full >> SHIFT);
    assign qb_next   = HASH_W'(q_reg * HASH_W'(BUCKETS));
    assign rem_raw   = u_reg - qb_reg;
    assign rem_fix   = (rem_raw >= HASH_W'(BUCKETS)) ? rem_raw - HASH_W'(BUCKETS) : rem_raw;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:  state_next = F_PROD;
            F_PROD: state_next = F_MOD;
            F_MOD:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = 1'b1;
        push_valid = 1'b0;
        case (state_reg)
            F_IDLE: busy = 1'b0;
            F_MOD:  push_valid = 1'b1;
            default:
            begin
                busy       = 1'b1;
                push_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
            u_reg   <= h_sum[HASH_W-1:0];
        end
        q_reg  <= q_next;
        qb_reg <= qb_next;
    end

    assign item   = req_reg;
    assign bucket = rem_fix[BW-1:0];

endmodule

// ===== hw/rtl/tkhm_fifo.sv =====
module tkhm_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);
    import tkhm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/tkhm_back.sv =====
module tkhm_back #(
    parameter int BUCKETS      = tkhm_pkg::BUCKETS_DEF,
    parameter int POOL_ENTRIES = tkhm_pkg::POOL_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  tkhm_pkg::req_t                      item,
    input  logic [$clog2(BUCKETS)-1:0]          item_bucket,
    output logic                                pop,
    output logic                                ready,
    output logic                                done,
    output logic signed [tkhm_pkg::VAL_W-1:0]   value_out,
    output logic                                found,
    output logic                                pool_full
);
    import tkhm_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int CW = $clog2(POOL_ENTRIES + 1);

    // memories: head and next links carry a valid bit above the index
    logic [PW:0]   head_mem [BUCKETS];
    logic [PW-1:0] tail_mem [BUCKETS];
    entry_t        ent_mem  [POOL_ENTRIES];
    logic [PW:0]   next_mem [POOL_ENTRIES];

    back_state_t state_reg, state_next;

    logic [BW-1:0]  clr_cnt_reg;
    logic [CW-1:0]  used_reg;
    req_t           cur_reg;
    logic [BW-1:0]  cur_bucket_reg;
    logic [PW-1:0]  link_idx_reg;
    logic [PW:0]    head_rd_reg;
    logic [PW-1:0]  tail_rd_reg;
    entry_t         ent_rd_reg;
    logic [PW:0]    nxt_rd_reg;

    logic                    done_reg, done_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic                    found_reg, found_next;
    logic                    full_reg, full_next;

    logic          head_we, tail_we, ent_we, next_we, used_inc;
    logic [BW-1:0] head_waddr;
    logic [PW:0]   head_wdata;
    logic [PW-1:0] next_waddr;
    logic [PW:0]   next_wdata;
    logic [PW-1:0] ent_raddr;
    logic          pool_empty_left;
    logic          key_match;
    logic          clr_last;

    assign pool_empty_left = (used_reg == CW'(POOL_ENTRIES));
    assign key_match = (ent_rd_reg.key_a == cur_reg.key_a) && (ent_rd_reg.key_b == cur_reg.key_b);
    assign clr_last  = (clr_cnt_reg == BW'(BUCKETS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = B_HEAD;
                end
            end
            B_HEAD:
            begin
                case (cur_reg.func)
                    FUNC_INSERT:
                    begin
                        if (!pool_empty_left && head_rd_reg[PW])
                        begin
                            state_next = B_LINK;
                        end
                        else
                        begin
                            state_next = B_IDLE;
                        end
                    end
                    FUNC_LOOKUP:
                    begin
                        state_next = head_rd_reg[PW] ? B_WALK : B_IDLE;
                    end
                    default: state_next = B_IDLE;
                endcase
            end
            B_WALK:
            begin
                if (key_match || !nxt_rd_reg[PW])
                begin
                    state_next = B_IDLE;
                end
            end
            B_LINK:  state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        head_we    = 1'b0;
        tail_we    = 1'b0;
        ent_we     = 1'b0;
        next_we    = 1'b0;
        used_inc   = 1'b0;
        head_waddr = cur_bucket_reg;
        head_wdata = {1'b1, used_reg[PW-1:0]};
        next_waddr = used_reg[PW-1:0];
        next_wdata = '0;
        ent_raddr  = nxt_rd_reg[PW-1:0];
        done_next  = 1'b0;
        value_next = VALUE_NONE;
        found_next = 1'b0;
        full_next  = 1'b0;
        case (state_reg)
            B_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_cnt_reg;
                head_wdata = '0;
            end
            B_IDLE:
            begin
                pop = item_valid;
            end
            B_HEAD:
            begin
                case (cur_reg.func)
                    FUNC_INSERT:
                    begin
                        done_next = 1'b1;
                        if (pool_empty_left)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            ent_we   = 1'b1;
                            next_we  = 1'b1;
                            tail_we  = 1'b1;
                            used_inc = 1'b1;
                            head_we  = !head_rd_reg[PW];
                        end
                    end
                    FUNC_LOOKUP:
                    begin
                        ent_raddr = head_rd_reg[PW-1:0];
                        done_next = !head_rd_reg[PW];
                    end
                    default: done_next = 1'b0;
                endcase
            end
            B_WALK:
            begin
                if (key_match)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    value_next = ent_rd_reg.value;
                end
                else if (!nxt_rd_reg[PW])
                begin
                    done_next = 1'b1;
                end
            end
            B_LINK:
            begin
                // old tail now points at the new entry
                next_we    = 1'b1;
                next_waddr = tail_rd_reg;
                next_wdata = {1'b1, link_idx_reg};
            end
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_cnt_reg <= '0;
            used_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == B_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (used_inc)
            begin
                used_reg <= used_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        found_reg <= found_next;
        full_reg  <= full_next;
        if (pop)
        begin
            cur_reg        <= item;
            cur_bucket_reg <= item_bucket;
            head_rd_reg    <= head_mem[item_bucket];
            tail_rd_reg    <= tail_mem[item_bucket];
        end
        if (state_reg == B_HEAD)
        begin
            link_idx_reg <= used_reg[PW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (tail_we)
        begin
            tail_mem[cur_bucket_reg] <= used_reg[PW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[used_reg[PW-1:0]] <= '{key_a: cur_reg.key_a, key_b: cur_reg.key_b,
                                           value: cur_reg.value};
        end
        ent_rd_reg <= ent_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        nxt_rd_reg <= next_mem[ent_raddr];
    end

    assign ready     = (state_reg != B_CLEAR);
    assign done      = done_reg;
    assign value_out = value_reg;
    assign found     = found_reg;
    assign pool_full = full_reg;

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(POOL_ENTRIES))
        else $error("entry count beyond pool size");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == B_HEAD || state_reg == B_WALK))
        else $error("result word without a finished insert or lookup");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(found_reg && full_reg))
        else $error("found and pool_full on the same word");

    a_full_used: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && full_reg) |-> (used_reg == CW'(POOL_ENTRIES)))
        else $error("pool_full while entries remain");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !item_valid)
        else $error("item queued during clearing pass");
`endif

endmodule

// ===== hw/rtl/two_key_chained_hash_map.sv =====
// Map from (key_a, key_b) pairs to 32-bit values, chained buckets over a
// fixed entry pool. Pulse start while busy is low to hand in an insert
// (func 0) or lookup (func 1); each word gives exactly one result word,
// shown for one cycle with done high, and it cannot be held off. After
// reset busy stays high while the bucket heads are cleared. The front end
// takes one word at a time (hash, two multiplies for the bucket modulo,
// final correction) and feeds a two-word queue, waiting while it is full.
// The back end spends a head step on an insert, plus a link step when
// appending to a non-empty chain, and a head step plus one walk step per
// chain entry visited on a lookup. Results come out in input order.
module two_key_chained_hash_map #(
    parameter int BUCKETS      = tkhm_pkg::BUCKETS_DEF,
    parameter int POOL_ENTRIES = tkhm_pkg::POOL_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                func,
    input  logic signed [tkhm_pkg::KEY_W-1:0]   key_a,
    input  logic signed [tkhm_pkg::KEY_W-1:0]   key_b,
    input  logic signed [tkhm_pkg::VAL_W-1:0]   value_in,
    output logic                                done,
    output logic signed [tkhm_pkg::VAL_W-1:0]   value_out,
    output logic                                found,
    output logic                                pool_full
);
    import tkhm_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int QW = $bits(req_t) + BW;

    req_t          in_req;
    logic          accept;
    logic          front_busy;
    logic          back_ready;
    logic          push_valid;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    req_t          front_item;
    logic [BW-1:0] front_bucket;
    logic [QW-1:0] q_out;
    req_t          back_item;
    logic [BW-1:0] back_bucket;

    assign in_req.func  = func;
    assign in_req.key_a = key_a;
    assign in_req.key_b = key_b;
    assign in_req.value = value_in;

    assign busy   = front_busy || !back_ready;
    assign accept = start && !busy;

    tkhm_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req        (in_req),
        .busy       (front_busy),
        .push_valid (push_valid),
        .push_ready (!q_full),
        .item       (front_item),
        .bucket     (front_bucket)
    );

    tkhm_fifo #(
        .W (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid && !q_full),
        .push_data ({front_item, front_bucket}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign back_item   = q_out[QW-1:BW];
    assign back_bucket = q_out[BW-1:0];

    tkhm_back #(
        .BUCKETS      (BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (!q_empty),
        .item        (back_item),
        .item_bucket (back_bucket),
        .pop         (q_pop),
        .ready       (back_ready),
        .done        (done),
        .value_out   (value_out),
        .found       (found),
        .pool_full   (pool_full)
    );

endmodule
